### hdl/edge_avoid_maneuver_sequencer_assert.svh
// ----------------------------------------------------------------------------
// edge avoid maneuver sequencer assertion macros
// concurrent checks clocked on the block clock, disabled during reset
// ----------------------------------------------------------------------------
`ifndef EDGE_AVOID_MANEUVER_SEQUENCER_ASSERT_SVH
`define EDGE_AVOID_MANEUVER_SEQUENCER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define EAMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define EAMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/eams_pkg.sv
// ----------------------------------------------------------------------------
// eams_pkg
// shared types and constants of the edge avoid maneuver sequencer
// ----------------------------------------------------------------------------
package eams_pkg;

    localparam int LEVEL_W  = 8;
    localparam int TICK_W   = 8;
    localparam int NUM_LANE = 4;
    localparam int CFG_IDX_W = 3;

    // register reset values
    localparam logic [7:0] THRESHOLD_RST       = 8'd100;
    localparam logic [7:0] BACKUP_TICKS_RST    = 8'd60;
    localparam logic [7:0] PUSH_TICKS_RST      = 8'd20;
    localparam logic [7:0] TIMEOUT_SHORT_RST   = 8'd80;
    localparam logic [7:0] TIMEOUT_LONG_RST    = 8'd110;
    localparam logic [7:0] TIMEOUT_INITIAL_RST = 8'd90;

    // sensor flag bit positions
    localparam int FLAG_FL = 0;
    localparam int FLAG_FR = 1;
    localparam int FLAG_RL = 2;
    localparam int FLAG_RR = 3;

    // sensor patterns the idle decision acts on
    localparam logic [3:0] PAT_ALL_ON   = 4'hF;
    localparam logic [3:0] PAT_FL_OUT   = 4'hE;
    localparam logic [3:0] PAT_FR_OUT   = 4'hD;
    localparam logic [3:0] PAT_REAR_OUT = 4'h3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD       = 3'd0,
        CFG_BACKUP_TICKS    = 3'd1,
        CFG_PUSH_TICKS      = 3'd2,
        CFG_TIMEOUT_SHORT   = 3'd3,
        CFG_TIMEOUT_LONG    = 3'd4,
        CFG_TIMEOUT_INITIAL = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_BACKUP = 3'd1,
        PH_TURN   = 3'd2,
        PH_PUSH   = 3'd3
    } t_phase;

    typedef enum logic [1:0] {
        DRV_OFF = 2'd0,
        DRV_FWD = 2'd1,
        DRV_REV = 2'd2
    } t_drive;

    // timing registers seen by the sequencer
    typedef struct packed {
        logic [TICK_W-1:0] backup_ticks;
        logic [TICK_W-1:0] push_ticks;
        logic [TICK_W-1:0] timeout_short;
        logic [TICK_W-1:0] timeout_long;
    } t_cfg;

    // direct load of the turn limit on a write of the initial timeout
    typedef struct packed {
        logic              en;
        logic [TICK_W-1:0] value;
    } t_limit_load;

    typedef struct packed {
        t_drive     left_drive;
        t_drive     right_drive;
        logic [3:0] sensor_flags;
        logic       busy_res;
    } t_result;

endpackage

### hdl/eams_if.sv
// ----------------------------------------------------------------------------
// eams_if
// valid/ready channels for sensor ticks and motor results
// ----------------------------------------------------------------------------
interface eams_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] front_left_level;
    logic [7:0] front_right_level;
    logic [7:0] rear_left_level;
    logic [7:0] rear_right_level;
    logic       coin;

    modport source (
        output valid, front_left_level, front_right_level,
               rear_left_level, rear_right_level, coin,
        input  ready
    );
    modport sink (
        input  valid, front_left_level, front_right_level,
               rear_left_level, rear_right_level, coin,
        output ready
    );
endinterface

interface eams_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] left_drive;
    logic [1:0] right_drive;
    logic [3:0] sensor_flags;
    logic       busy_res;

    modport source (
        output valid, left_drive, right_drive, sensor_flags, busy_res,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, sensor_flags, busy_res,
        output ready
    );
endinterface

### hdl/eams_lane.sv
// ----------------------------------------------------------------------------
// eams_lane
// one floor sensor lane: level against threshold gives the on-surface flag
// ----------------------------------------------------------------------------
module eams_lane import eams_pkg::*; (
    input  logic [LEVEL_W-1:0] i_level,
    input  logic [LEVEL_W-1:0] i_threshold,
    output logic               o_on
);

    // on-surface when strictly above threshold
    assign o_on = (i_level > i_threshold);

endmodule

### hdl/eams_fsm.sv
// ----------------------------------------------------------------------------
// eams_fsm
// merges the lane flags into the maneuver decision and holds the motor state
// ----------------------------------------------------------------------------
module eams_fsm import eams_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [3:0]  i_flags,
    input  logic        i_coin,
    input  t_cfg        i_cfg,
    input  t_limit_load i_limit_load,
    output t_result     o_res
);

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [TICK_W-1:0] r_limit, n_limit;
    logic              r_side, n_side;
    t_drive            r_left, n_left;
    t_drive            r_right, n_right;
    logic [TICK_W-1:0] reroll_limit;

    assign reroll_limit = i_coin ? i_cfg.timeout_long : i_cfg.timeout_short;

    // next state for one tick
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_limit = r_limit;
        n_side  = r_side;
        n_left  = r_left;
        n_right = r_right;
        case (r_phase)
            PH_BACKUP: begin
                if (r_tick < i_cfg.backup_ticks) begin
                    n_tick = r_tick + 1'b1;
                end else begin
                    n_left  = r_side ? DRV_REV : DRV_OFF;
                    n_right = r_side ? DRV_OFF : DRV_REV;
                    n_tick  = '0;
                    n_phase = PH_TURN;
                end
            end
            PH_TURN: begin
                if (!i_flags[FLAG_RL] || !i_flags[FLAG_RR] || (r_tick >= r_limit)) begin
                    n_limit = reroll_limit;
                    n_phase = PH_IDLE;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            PH_PUSH: begin
                if (r_tick < i_cfg.push_ticks) begin
                    n_tick = r_tick + 1'b1;
                end else begin
                    n_limit = reroll_limit;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                // idle decision on the sensor pattern
                n_phase = PH_IDLE;
                case (i_flags)
                    PAT_ALL_ON: begin
                        n_left  = DRV_FWD;
                        n_right = DRV_FWD;
                        n_limit = reroll_limit;
                    end
                    PAT_FL_OUT, PAT_FR_OUT: begin
                        n_left  = DRV_REV;
                        n_right = DRV_REV;
                        n_side  = (i_flags == PAT_FR_OUT);
                        n_tick  = '0;
                        n_phase = PH_BACKUP;
                    end
                    PAT_REAR_OUT: begin
                        n_left  = DRV_FWD;
                        n_right = DRV_FWD;
                        n_tick  = '0;
                        n_phase = PH_PUSH;
                    end
                    default: begin
                        n_limit = reroll_limit;
                    end
                endcase
            end
        endcase
    end

    // result of the tick being accepted
    always_comb begin
        o_res.left_drive   = n_left;
        o_res.right_drive  = n_right;
        o_res.sensor_flags = i_flags;
        o_res.busy_res     = (n_phase != PH_IDLE);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_limit <= TIMEOUT_INITIAL_RST;
            r_side  <= 1'b0;
            r_left  <= DRV_OFF;
            r_right <= DRV_OFF;
        end else if (i_limit_load.en) begin
            r_limit <= i_limit_load.value;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_limit <= n_limit;
            r_side  <= n_side;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

endmodule

### hdl/eams_skid.sv
// ----------------------------------------------------------------------------
// eams_skid
// two-entry result queue between the sequencer and the output channel
// ----------------------------------------------------------------------------
module eams_skid import eams_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    t_result    r_buf [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_buf[r_rptr];
    assign pop     = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/edge_avoid_maneuver_sequencer.sv
// ----------------------------------------------------------------------------
// edge_avoid_maneuver_sequencer
// floor-edge avoidance sequencer: sensor ticks in, motor commands out
// ----------------------------------------------------------------------------
// usage
//   i_in carries one 10 ms tick per transaction: four 8-bit floor levels and
//   a coin bit. o_out returns exactly one transaction per tick with the left
//   and right motor codes, the on-surface flags and the busy flag.
//   four comparator lanes judge the sensors in parallel, the sequencer merges
//   their flags and updates its phase, counter and turn limit in the cycle the
//   tick is taken. the result is then queued and offered on o_out behind any
//   older result. throughput is one transaction per cycle while the queue has
//   room, as the sequencer updates its state in the cycle a tick is taken.
//   a two-entry result queue parts the channels: i_in stays ready while the
//   queue has room, so one tick is still taken while a result waits; with two
//   results stalled, i_in.ready drops until o_out takes one.
//   registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle,
//   which the user must keep to, the block does not enforce it; a write of the
//   initial timeout also loads the turn limit at once. synchronous reset
//   restores register defaults, idle phase, motors off and an empty queue.
// ----------------------------------------------------------------------------
`include "edge_avoid_maneuver_sequencer_assert.svh"

module edge_avoid_maneuver_sequencer import eams_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    eams_in_if.sink              i_in,
    eams_out_if.source           o_out
);

    logic [LEVEL_W-1:0] r_threshold;
    logic [TICK_W-1:0]  r_backup_ticks;
    logic [TICK_W-1:0]  r_push_ticks;
    logic [TICK_W-1:0]  r_timeout_short;
    logic [TICK_W-1:0]  r_timeout_long;

    logic [LEVEL_W-1:0] levels [NUM_LANE];
    logic [3:0]         flags;
    logic               fire;
    logic               q_ready;
    t_cfg               cfg;
    t_limit_load        limit_load;
    t_result            res;
    t_result            out_res;

    // configuration registers
    // the initial timeout only matters as a direct load of the turn limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold       <= THRESHOLD_RST;
            r_backup_ticks    <= BACKUP_TICKS_RST;
            r_push_ticks      <= PUSH_TICKS_RST;
            r_timeout_short   <= TIMEOUT_SHORT_RST;
            r_timeout_long    <= TIMEOUT_LONG_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD:       r_threshold       <= i_cfg_data;
                CFG_BACKUP_TICKS:    r_backup_ticks    <= i_cfg_data;
                CFG_PUSH_TICKS:      r_push_ticks      <= i_cfg_data;
                CFG_TIMEOUT_SHORT:   r_timeout_short   <= i_cfg_data;
                CFG_TIMEOUT_LONG:    r_timeout_long    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.backup_ticks  = r_backup_ticks;
    assign cfg.push_ticks    = r_push_ticks;
    assign cfg.timeout_short = r_timeout_short;
    assign cfg.timeout_long  = r_timeout_long;

    assign limit_load.en    = i_cfg_we && (i_cfg_idx == CFG_TIMEOUT_INITIAL);
    assign limit_load.value = i_cfg_data;

    // sensor lanes
    assign levels[FLAG_FL] = i_in.front_left_level;
    assign levels[FLAG_FR] = i_in.front_right_level;
    assign levels[FLAG_RL] = i_in.rear_left_level;
    assign levels[FLAG_RR] = i_in.rear_right_level;

    for (genvar g = 0; g < NUM_LANE; g++) begin : g_lane
        eams_lane u_lane (
            .i_level     (levels[g]),
            .i_threshold (r_threshold),
            .o_on        (flags[g])
        );
    end

    // handshake on the input channel
    assign i_in.ready = q_ready;
    assign fire       = i_in.valid && q_ready;

    // sequencer merging the lane flags
    eams_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_flags      (flags),
        .i_coin       (i_in.coin),
        .i_cfg        (cfg),
        .i_limit_load (limit_load),
        .o_res        (res)
    );

    // result queue
    eams_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res),
        .o_ready (q_ready),
        .o_valid (o_out.valid),
        .o_data  (out_res),
        .i_ready (o_out.ready)
    );

    assign o_out.left_drive   = out_res.left_drive;
    assign o_out.right_drive  = out_res.right_drive;
    assign o_out.sensor_flags = out_res.sensor_flags;
    assign o_out.busy_res     = out_res.busy_res;

    // checks
    `EAMS_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, fire, o_out.valid, "accepted tick produced no result")
    `EAMS_ASSERT_SAME(a_empty_is_ready, i_clk, i_rst_n, !o_out.valid, i_in.ready, "empty queue refuses a tick")
    `EAMS_ASSERT_SAME(a_drive_codes, i_clk, i_rst_n, o_out.valid, (o_out.left_drive != 2'd3) && (o_out.right_drive != 2'd3), "undefined motor code")

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the edge avoid maneuver sequencer: sensor ticks are
// shaped by the predicted phase so that backup, turn and push maneuvers run
// to completion, every result is compared with a cycle-free model of the
// sequencer, and both channels idle at random
// ----------------------------------------------------------------------------
module tb_top;
    import eams_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 4;

    // one sensor tick as driven on the input channel
    typedef struct packed {
        logic [7:0] fl;
        logic [7:0] fr;
        logic [7:0] rl;
        logic [7:0] rr;
        logic       coin;
    } t_sensor_tick;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0]           i_cfg_data;

    eams_in_if  in_if ();
    eams_out_if out_if ();

    edge_avoid_maneuver_sequencer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // register copies
    logic [7:0] threshold_r;
    logic [7:0] backup_ticks_r;
    logic [7:0] push_ticks_r;
    logic [7:0] timeout_short_r;
    logic [7:0] timeout_long_r;

    // sequencer state copies
    t_phase     seq_phase;
    logic [7:0] tick_cnt;
    logic [7:0] turn_limit;
    logic       turn_side;
    t_drive     left_hold;
    t_drive     right_hold;

    t_result    motor_cmd_q[$];
    t_result    want_cmd;
    int         err_count;
    int         quiet_cycles;
    bit         src_gap_en;
    bit         sink_stall_en;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------------
    function automatic void reset_sequencer();
        threshold_r       = THRESHOLD_RST;
        backup_ticks_r    = BACKUP_TICKS_RST;
        push_ticks_r      = PUSH_TICKS_RST;
        timeout_short_r   = TIMEOUT_SHORT_RST;
        timeout_long_r    = TIMEOUT_LONG_RST;
        seq_phase         = PH_IDLE;
        tick_cnt          = '0;
        turn_limit        = TIMEOUT_INITIAL_RST;
        turn_side         = 1'b0;
        left_hold         = DRV_OFF;
        right_hold        = DRV_OFF;
    endfunction

    function automatic void pick_turn_limit(input logic coin);
        turn_limit = coin ? timeout_long_r : timeout_short_r;
        seq_phase  = PH_IDLE;
    endfunction

    function automatic t_result advance_sequencer(input t_sensor_tick tick);
        logic [3:0] flags;
        t_result    res;
        flags[FLAG_FL] = tick.fl > threshold_r;
        flags[FLAG_FR] = tick.fr > threshold_r;
        flags[FLAG_RL] = tick.rl > threshold_r;
        flags[FLAG_RR] = tick.rr > threshold_r;
        case (seq_phase)
            PH_BACKUP: begin
                if (tick_cnt < backup_ticks_r) begin
                    tick_cnt++;
                end else begin
                    left_hold  = turn_side ? DRV_REV : DRV_OFF;
                    right_hold = turn_side ? DRV_OFF : DRV_REV;
                    tick_cnt   = '0;
                    seq_phase  = PH_TURN;
                end
            end
            PH_TURN: begin
                // a rear sensor over the edge ends the turn early
                if (!flags[FLAG_RL] || !flags[FLAG_RR] || tick_cnt >= turn_limit)
                    pick_turn_limit(tick.coin);
                else
                    tick_cnt++;
            end
            PH_PUSH: begin
                if (tick_cnt < push_ticks_r)
                    tick_cnt++;
                else
                    pick_turn_limit(tick.coin);
            end
            default: begin
                if (flags == PAT_ALL_ON) begin
                    left_hold  = DRV_FWD;
                    right_hold = DRV_FWD;
                    pick_turn_limit(tick.coin);
                end else if (flags == PAT_FL_OUT || flags == PAT_FR_OUT) begin
                    left_hold  = DRV_REV;
                    right_hold = DRV_REV;
                    turn_side  = (flags == PAT_FR_OUT);
                    tick_cnt   = '0;
                    seq_phase  = PH_BACKUP;
                end else if (flags == PAT_REAR_OUT) begin
                    left_hold  = DRV_FWD;
                    right_hold = DRV_FWD;
                    tick_cnt   = '0;
                    seq_phase  = PH_PUSH;
                end else begin
                    pick_turn_limit(tick.coin);
                end
            end
        endcase
        res.left_drive   = left_hold;
        res.right_drive  = right_hold;
        res.sensor_flags = flags;
        res.busy_res     = (seq_phase != PH_IDLE);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // level on either side of the threshold, boundaries favoured
    function automatic logic [7:0] level_for(input logic on_surface);
        int pick;
        pick = $urandom_range(0, 3);
        if (on_surface && threshold_r != 8'hFF) begin
            if (pick == 0)
                return threshold_r + 8'd1;
            else if (pick == 1)
                return 8'hFF;
            return 8'($urandom_range(int'(threshold_r) + 1, 255));
        end else if (!on_surface) begin
            if (pick == 0)
                return threshold_r;
            else if (pick == 1)
                return 8'h00;
            return 8'($urandom_range(0, int'(threshold_r)));
        end
        // no level reads on-surface at the top threshold
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_sensor_tick tick_from_flags(input logic [3:0] flags,
                                                     input logic coin);
        t_sensor_tick tick;
        tick.fl   = level_for(flags[FLAG_FL]);
        tick.fr   = level_for(flags[FLAG_FR]);
        tick.rl   = level_for(flags[FLAG_RL]);
        tick.rr   = level_for(flags[FLAG_RR]);
        tick.coin = coin;
        return tick;
    endfunction

    // pattern weighted towards what moves the sequencer on from its phase
    function automatic t_sensor_tick draw_tick();
        int         pick;
        logic [3:0] flags;
        pick  = $urandom_range(0, 99);
        flags = 4'($urandom_range(0, 15));
        if (seq_phase == PH_IDLE) begin
            if (pick < 30)
                flags = PAT_ALL_ON;
            else if (pick < 50)
                flags = PAT_FL_OUT;
            else if (pick < 70)
                flags = PAT_FR_OUT;
            else if (pick < 85)
                flags = PAT_REAR_OUT;
        end else if (seq_phase == PH_TURN && pick < 85) begin
            flags[FLAG_RL] = 1'b1;
            flags[FLAG_RR] = 1'b1;
        end
        return tick_from_flags(flags, 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_tick(input t_sensor_tick tick);
        int gap;
        gap = src_gap_en ? $urandom_range(0, 9) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
        end
        @(negedge i_clk);
        in_if.front_left_level  = tick.fl;
        in_if.front_right_level = tick.fr;
        in_if.rear_left_level   = tick.rl;
        in_if.rear_right_level  = tick.rr;
        in_if.coin              = tick.coin;
        in_if.valid             = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        motor_cmd_q.push_back(advance_sequencer(tick));
    endtask

    task automatic send_flags(input logic [3:0] flags, input logic coin);
        send_tick(tick_from_flags(flags, coin));
    endtask

    // stop sending and let every pending result come back
    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (motor_cmd_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_THRESHOLD:       threshold_r     = value;
            CFG_BACKUP_TICKS:    backup_ticks_r  = value;
            CFG_PUSH_TICKS:      push_ticks_r    = value;
            CFG_TIMEOUT_SHORT:   timeout_short_r = value;
            CFG_TIMEOUT_LONG:    timeout_long_r  = value;
            CFG_TIMEOUT_INITIAL: turn_limit      = value;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [7:0] thr, input logic [7:0] backup,
                              input logic [7:0] push, input logic [7:0] t_short,
                              input logic [7:0] t_long, input logic [7:0] t_init);
        drain();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_BACKUP_TICKS, backup);
        write_reg(CFG_PUSH_TICKS, push);
        write_reg(CFG_TIMEOUT_SHORT, t_short);
        write_reg(CFG_TIMEOUT_LONG, t_long);
        write_reg(CFG_TIMEOUT_INITIAL, t_init);
    endtask

    // random ticks, idling mode redrawn in stretches
    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                src_gap_en    = 1'($urandom_range(0, 1));
                sink_stall_en = 1'($urandom_range(0, 1));
            end
            send_tick(draw_tick());
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // walk through every decision and maneuver exit with short durations
    task automatic test_directed();
        t_sensor_tick tick;
        set_timing(THRESHOLD_RST, 8'd1, 8'd1, 8'd2, 8'd3, 8'd2);
        src_gap_en    = 1'b0;
        sink_stall_en = 1'b0;
        // field extremes: all on, then all off
        tick = '{fl: 8'hFF, fr: 8'hFF, rl: 8'hFF, rr: 8'hFF, coin: 1'b1};
        send_tick(tick);
        tick = '{fl: 8'h00, fr: 8'h00, rl: 8'h00, rr: 8'h00, coin: 1'b0};
        send_tick(tick);
        // front left exactly at threshold reads off-surface
        tick = '{fl: THRESHOLD_RST, fr: THRESHOLD_RST + 8'd1,
                 rl: THRESHOLD_RST + 8'd1, rr: 8'hFF, coin: 1'b0};
        send_tick(tick);
        send_flags(4'h0, 1'b1);
        send_flags(4'h5, 1'b0);
        // turn cut short by a rear sensor leaving the surface
        send_flags(PAT_ALL_ON, 1'b1);
        send_flags(4'hB, 1'b1);
        // mirrored maneuver, turn runs to its limit
        send_flags(PAT_FR_OUT, 1'b0);
        send_flags(4'h0, 1'b0);
        send_flags(4'hF, 1'b0);
        repeat (5) send_flags(PAT_ALL_ON, 1'b0);
        // forward push with both rear sensors out
        send_flags(PAT_REAR_OUT, 1'b1);
        repeat (3) send_flags(4'h0, 1'b0);
        // pattern with no decision keeps the motors
        send_flags(4'h9, 1'b1);
        send_flags(4'h6, 1'b0);
    endtask

    task automatic test_zero_durations();
        set_timing(8'd128, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        src_gap_en    = 1'b1;
        sink_stall_en = 1'b1;
        repeat (20) send_tick(draw_tick());
    endtask

    task automatic test_threshold_extremes();
        set_timing(8'd0, 8'd3, 8'd2, 8'd4, 8'd6, 8'd5);
        run_random(40);
        set_timing(8'd255, 8'd3, 8'd2, 8'd4, 8'd6, 8'd5);
        run_random(30);
    endtask

    task automatic test_long_maneuvers();
        set_timing(8'd64, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255);
        run_random(300);
    endtask

    task automatic test_random_timing();
        for (int round = 0; round < 6; round++) begin
            set_timing(8'($urandom_range(30, 220)), 8'($urandom_range(0, 12)),
                       8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                       8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)));
            run_random(80);
        end
    endtask

    // ------------------------------------------------------------------------
    // result channel: random stalls per transaction
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        out_if.ready = 1'b0;
        forever begin
            stall = sink_stall_en ? $urandom_range(0, 9) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                out_if.ready = 1'b0;
            end
            @(negedge i_clk);
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && i_rst_n));
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // compare each result with the oldest pending command
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (motor_cmd_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want_cmd = motor_cmd_q.pop_front();
                if (out_if.left_drive !== want_cmd.left_drive)
                    report_mismatch("left_drive", out_if.left_drive, want_cmd.left_drive);
                if (out_if.right_drive !== want_cmd.right_drive)
                    report_mismatch("right_drive", out_if.right_drive,
                                    want_cmd.right_drive);
                if (out_if.sensor_flags !== want_cmd.sensor_flags)
                    report_mismatch("sensor_flags", out_if.sensor_flags,
                                    want_cmd.sensor_flags);
                if (out_if.busy_res !== want_cmd.busy_res)
                    report_mismatch("busy_res", out_if.busy_res, want_cmd.busy_res);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog expired with %0d results pending", motor_cmd_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        err_count               = 0;
        src_gap_en              = 1'b0;
        sink_stall_en           = 1'b0;
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_idx               = CFG_THRESHOLD;
        i_cfg_data              = '0;
        in_if.valid             = 1'b0;
        in_if.front_left_level  = '0;
        in_if.front_right_level = '0;
        in_if.rear_left_level   = '0;
        in_if.rear_right_level  = '0;
        in_if.coin              = 1'b0;
        reset_sequencer();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_zero_durations();
        test_threshold_extremes();
        test_random_timing();
        test_long_maneuvers();

        drain();
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/eams_pkg.sv
hdl/eams_if.sv
hdl/eams_lane.sv
hdl/eams_fsm.sv
hdl/eams_skid.sv
hdl/edge_avoid_maneuver_sequencer.sv
dv/tb_top.sv
